### rtl/assert_macros.svh
// shared assertion macros, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication check
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/hsl_pkg.sv
package hsl_pkg;

  // unsigned fixed point, 16 fractional bits, range 0..1.0 inclusive
  localparam int FRAC_W = 16;
  localparam int Q_W    = FRAC_W + 1;

  typedef logic [Q_W-1:0] q_t;
  // channel level before byte scaling, may exceed 1.0 slightly
  typedef logic [Q_W:0]   val_t;

  localparam q_t Q_ONE        = q_t'(65536);
  localparam q_t Q_HALF       = q_t'(32768);
  localparam q_t Q_THIRD      = q_t'(21845);
  localparam q_t Q_TWO_THIRDS = q_t'(43691);

  // per-item control that travels beside the data
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       gray;
    logic [7:0] lum;
  } pix_meta_t;

endpackage

### rtl/hsl_to_rgb_pixel.sv
// HSL to RGB pixel converter.
// Input channel: hue, saturation, lightness and last_pixel are taken at a
// rising clock edge with start high and busy low. busy is high during reset
// and for the first cycle after it, so one item can be taken every clock.
// Output channel: red, green, blue and frame_end are shown for one cycle with
// done high; the receiver takes them at the end of that cycle and cannot hold
// them off, so nothing in the block ever stalls.
// An item taken with start high and busy low reaches done through six
// register stages (byte to fixed point, helper levels, segment pick,
// ramp multiply, segment select, byte scaling).
// Throughput: one item per clock, set by the fully pipelined datapath with
// one 17x17 multiplier per channel plus one shared for the helper levels.
// frame_end is a copy of last_pixel; zero saturation gives the lightness
// byte on all three channels.
// Reset (synchronous, active high) drops every item in flight and clears done.
`include "assert_macros.svh"

module hsl_to_rgb_pixel
  import hsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] lightness,
  input  logic       last_pixel,
  output logic       done,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic       frame_end
);

  // level times 255, fraction dropped, clamped to a byte
  function automatic logic [7:0] q_to_byte(input val_t v);
    logic [Q_W+8:0] scaled;
    scaled = {v, 8'b0} - {8'b0, v};
    if (scaled[Q_W+8:FRAC_W+8] != '0) begin
      q_to_byte = 8'hFF;
    end else begin
      q_to_byte = scaled[FRAC_W+7:FRAC_W];
    end
  endfunction

  pix_meta_t meta2;
  pix_meta_t meta3;
  pix_meta_t meta4;
  pix_meta_t meta5;
  q_t        v1;
  q_t        v2;
  q_t        t_red;
  q_t        t_green;
  q_t        t_blue;
  val_t      val_red;
  val_t      val_green;
  val_t      val_blue;

  // busy only while coming out of reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  hsl_levels u_levels (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .last_pixel (last_pixel),
    .meta       (meta2),
    .v1         (v1),
    .v2         (v2),
    .t_red      (t_red),
    .t_green    (t_green),
    .t_blue     (t_blue)
  );

  hsl_chan u_red   (.clk(clk), .t(t_red),   .v1(v1), .v2(v2), .value(val_red));
  hsl_chan u_green (.clk(clk), .t(t_green), .v1(v1), .v2(v2), .value(val_green));
  hsl_chan u_blue  (.clk(clk), .t(t_blue),  .v1(v1), .v2(v2), .value(val_blue));

  // item control alongside the channel stages
  always_ff @(posedge clk) begin
    if (rst) begin
      meta3 <= '0;
      meta4 <= '0;
      meta5 <= '0;
    end else begin
      meta3 <= meta2;
      meta4 <= meta3;
      meta5 <= meta4;
    end
  end

  // output stage: byte scaling and gray bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= meta5.valid;
    end
    frame_end <= meta5.last;
    if (meta5.gray) begin
      red   <= meta5.lum;
      green <= meta5.lum;
      blue  <= meta5.lum;
    end else begin
      red   <= q_to_byte(val_red);
      green <= q_to_byte(val_green);
      blue  <= q_to_byte(val_blue);
    end
  end

  `ASSERT_IMPLY(a_done_from_item, clk, rst, done, $past(start && !busy, 6))
  `ASSERT_IMPLY(a_flag_follows, clk, rst, done, frame_end == $past(last_pixel, 6))
  `ASSERT_IMPLY(a_gray_bypass, clk, rst, done && $past(saturation == 8'd0, 6), (red == $past(lightness, 6)) && (green == red) && (blue == red))
  `ASSERT_NEXT(a_never_busy, clk, rst, !rst, !busy)

endmodule

### rtl/hsl_levels.sv
module hsl_levels
  import hsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] lightness,
  input  logic       last_pixel,
  output pix_meta_t  meta,
  output q_t         v1,
  output q_t         v2,
  output q_t         t_red,
  output q_t         t_green,
  output q_t         t_blue
);

  // byte to q: ceil(v * 65536 / 255) = v * 257 + (v != 0)
  function automatic q_t byte_to_q(input logic [7:0] v);
    byte_to_q = {1'b0, v, v} + q_t'(v != 8'd0);
  endfunction

  pix_meta_t meta1;
  q_t        h1;
  q_t        s1;
  q_t        l1;

  logic [2*Q_W-1:0] sl_prod;
  q_t               sl_frac;
  logic [Q_W:0]     v2_next;
  logic [Q_W:0]     v1_next;
  logic [Q_W:0]     t_red_sum;
  q_t               t_red_next;
  q_t               t_blue_next;

  // stage 1: bytes to fixed point
  always_ff @(posedge clk) begin
    if (rst) begin
      meta1 <= '0;
    end else begin
      meta1.valid <= in_valid;
      meta1.last  <= last_pixel;
      meta1.gray  <= (saturation == 8'd0);
      meta1.lum   <= lightness;
    end
    h1 <= byte_to_q(hue);
    s1 <= byte_to_q(saturation);
    l1 <= byte_to_q(lightness);
  end

  // helper levels v2 and v1
  assign sl_prod = s1 * l1;
  assign sl_frac = sl_prod[Q_W+FRAC_W-1:FRAC_W];

  always_comb begin
    if (l1 < Q_HALF) begin
      v2_next = {1'b0, l1} + {1'b0, sl_frac};
    end else begin
      v2_next = {1'b0, l1} + {1'b0, s1} - {1'b0, sl_frac};
    end
    v1_next = {l1, 1'b0} - v2_next;
  end

  // hue offsets of plus and minus one third, wrapped into 0..1
  assign t_red_sum = {1'b0, h1} + {1'b0, Q_THIRD};

  always_comb begin
    if (t_red_sum > {1'b0, Q_ONE}) begin
      t_red_next = q_t'(t_red_sum - {1'b0, Q_ONE});
    end else begin
      t_red_next = q_t'(t_red_sum);
    end
    if (h1 < Q_THIRD) begin
      t_blue_next = h1 + Q_TWO_THIRDS;
    end else begin
      t_blue_next = h1 - Q_THIRD;
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      meta <= '0;
    end else begin
      meta <= meta1;
    end
    v2      <= q_t'(v2_next);
    v1      <= q_t'(v1_next);
    t_red   <= t_red_next;
    t_green <= h1;
    t_blue  <= t_blue_next;
  end

endmodule

### rtl/hsl_chan.sv
module hsl_chan
  import hsl_pkg::*;
(
  input  logic clk,
  input  q_t   t,
  input  q_t   v1,
  input  q_t   v2,
  output val_t value
);

  localparam logic [1:0] SEG_RISE    = 2'd0;
  localparam logic [1:0] SEG_PLATEAU = 2'd1;
  localparam logic [1:0] SEG_FALL    = 2'd2;
  localparam logic [1:0] SEG_FLOOR   = 2'd3;

  // 6 * t < 1.0 exactly when t is below this bound
  localparam q_t T_SIXTH = q_t'(10923);

  logic [1:0] seg_next;
  q_t         fall_dist;
  logic [Q_W+2:0] six_t;
  logic [Q_W+2:0] six_fall;
  q_t         mul_next;
  q_t         d_next;

  logic [1:0] seg_a;
  q_t         d_a;
  q_t         mul_a;
  q_t         v1_a;
  q_t         v2_a;

  logic [2*Q_W-1:0] prod;
  logic [1:0] seg_b;
  val_t       ramp_b;
  q_t         v1_b;
  q_t         v2_b;

  val_t       value_next;

  // segment pick and ramp factor
  assign fall_dist = Q_TWO_THIRDS - t;
  assign six_t     = {t, 2'b00} + {1'b0, t, 1'b0};
  assign six_fall  = {fall_dist, 2'b00} + {1'b0, fall_dist, 1'b0};

  always_comb begin
    d_next = (v2 >= v1) ? (v2 - v1) : '0;
    if (t < T_SIXTH) begin
      seg_next = SEG_RISE;
      mul_next = q_t'(six_t);
    end else if (t < Q_HALF) begin
      seg_next = SEG_PLATEAU;
      mul_next = '0;
    end else if (t < Q_TWO_THIRDS) begin
      seg_next = SEG_FALL;
      mul_next = q_t'(six_fall);
    end else begin
      seg_next = SEG_FLOOR;
      mul_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    seg_a <= seg_next;
    d_a   <= d_next;
    mul_a <= mul_next;
    v1_a  <= v1;
    v2_a  <= v2;
  end

  // ramp height: d times factor, fraction dropped
  assign prod = d_a * mul_a;

  always_ff @(posedge clk) begin
    seg_b  <= seg_a;
    ramp_b <= {1'b0, prod[Q_W+FRAC_W-1:FRAC_W]};
    v1_b   <= v1_a;
    v2_b   <= v2_a;
  end

  // channel level by segment
  always_comb begin
    case (seg_b)
      SEG_RISE, SEG_FALL: value_next = {1'b0, v1_b} + ramp_b;
      SEG_PLATEAU:        value_next = {1'b0, v2_b};
      default:            value_next = {1'b0, v1_b};
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
